>>> rtl/spq_pkg.sv
// shared types and constants for the sorted point queue
package spq_pkg;

  localparam int DEPTH = 16;
  localparam int CW    = $clog2(DEPTH + 1);
  localparam int IW    = $clog2(DEPTH);
  localparam int KEY_W = 32;
  localparam int DUP_W = 4;

  typedef enum logic [2:0] {
    OP_INSERT = 3'd0,
    OP_FIRST  = 3'd1,
    OP_LAST   = 3'd2,
    OP_AT     = 3'd3,
    OP_DEDUP  = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    CMD_HOLD,
    CMD_INS,
    CMD_DEL
  } cmd_kind_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SQUARE,
    S_EXEC,
    S_DEDUP
  } state_t;

  typedef struct packed {
    logic [KEY_W-1:0]  key;
    logic signed [15:0] x;
    logic signed [15:0] y;
  } point_t;

  typedef struct packed {
    cmd_kind_t       kind;
    logic [IW-1:0]   idx;
    logic [CW-1:0]   count;
    point_t          pt;
  } cmd_t;

endpackage

>>> rtl/spq_cell.sv
// one slot of the ordered row: holds a point and shifts with its neighbors
module spq_cell (
  input  logic               clk,
  input  spq_pkg::cmd_t      cmd,
  input  logic [spq_pkg::IW-1:0] my_idx,
  input  spq_pkg::point_t    left_pt,
  input  spq_pkg::point_t    right_pt,
  input  logic               left_sh,
  output logic               sh,
  output spq_pkg::point_t    pt
);
  import spq_pkg::*;

  logic   less;
  logic   occupied;
  logic   at_end;
  point_t pt_next;

  // new point strictly below this one in (key, x, y) order
  assign less = (cmd.pt.key < pt.key) ||
                ((cmd.pt.key == pt.key) && ((cmd.pt.x < pt.x) ||
                 ((cmd.pt.x == pt.x) && (cmd.pt.y < pt.y))));
  assign occupied = CW'(my_idx) < cmd.count;
  assign at_end   = CW'(my_idx) == cmd.count;
  assign sh       = occupied && less;

  always_comb begin
    pt_next = pt;
    case (cmd.kind)
      CMD_INS: begin
        if (left_sh) begin
          pt_next = left_pt;
        end else if (sh || at_end) begin
          pt_next = cmd.pt;
        end
      end
      CMD_DEL: begin
        if ((my_idx >= cmd.idx) && ((CW'(my_idx) + CW'(1)) < cmd.count)) begin
          pt_next = right_pt;
        end
      end
      default: pt_next = pt;
    endcase
  end

  always_ff @(posedge clk) begin
    pt <= pt_next;
  end

endmodule

>>> rtl/sorted_point_queue.sv
// sorted point queue: ordered row of cells with a small sequencer
//
//  channel | signals                               | direction
//  in      | in_valid in_stall opcode coord_x/y pos | word in
//  out     | out_valid out_stall status out_x/y dup | word out
//
// insert goes through S_SQUARE (squares registered), then S_EXEC (compare and shift);
// removals go straight to S_EXEC; delete duplicates scans the stored points in S_DEDUP.
// in_stall is high from accept until the result is registered.
// rst empties the queue and the result register; entry contents are kept.
// a new word is taken while a result still waits; out_stall holds the sequencer
module sorted_point_queue (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  opcode,
  input  logic signed [15:0] coord_x,
  input  logic signed [15:0] coord_y,
  input  logic [3:0]  position,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  status,
  output logic signed [15:0] out_x,
  output logic signed [15:0] out_y,
  output logic [3:0]  dup_count
);
  import spq_pkg::*;

  state_t state, state_next;
  logic [2:0]          op_r;
  logic signed [15:0]  px, py;
  logic [3:0]          pos_r;
  logic [CW-1:0]       count, count_next;
  logic [CW-1:0]       r_idx;
  logic [DUP_W-1:0]    dups;
  logic [KEY_W-1:0]    sq_x, sq_y;
  logic signed [KEY_W-1:0] ex, ey;

  cmd_t   cmd;
  point_t cell_pt [DEPTH];
  logic   cell_sh [DEPTH];

  logic        slot_free, accept, finish, rem_ok, dedup_done, dup_hit;
  logic [IW-1:0] rem_idx;
  status_t     res_status;

  assign accept    = in_valid && !in_stall;
  assign in_stall  = (state != S_IDLE);
  assign slot_free = !out_valid || !out_stall;
  assign ex = KEY_W'(px);
  assign ey = KEY_W'(py);

  genvar gi;
  generate
    for (gi = 0; gi < DEPTH; gi++) begin : g_cell
      spq_cell u_cell (
        .clk      (clk),
        .cmd      (cmd),
        .my_idx   (IW'(gi)),
        .left_pt  ((gi == 0) ? cmd.pt : cell_pt[(gi == 0) ? 0 : gi - 1]),
        .right_pt ((gi == DEPTH - 1) ? cell_pt[gi] : cell_pt[(gi == DEPTH - 1) ? gi : gi + 1]),
        .left_sh  ((gi == 0) ? 1'b0 : cell_sh[(gi == 0) ? 0 : gi - 1]),
        .sh       (cell_sh[gi]),
        .pt       (cell_pt[gi])
      );
    end
  endgenerate

  // removal index and range check
  always_comb begin
    rem_idx = '0;
    rem_ok  = 1'b0;
    case (op_r)
      OP_FIRST: begin
        rem_idx = '0;
        rem_ok  = count != '0;
      end
      OP_LAST: begin
        rem_idx = IW'(count - CW'(1));
        rem_ok  = count != '0;
      end
      OP_AT: begin
        rem_idx = IW'(pos_r);
        rem_ok  = 32'(pos_r) < 32'(count);
      end
      default: begin
        rem_idx = '0;
        rem_ok  = 1'b0;
      end
    endcase
  end

  assign dedup_done = (count < CW'(2)) || (r_idx >= count);
  assign dup_hit = !dedup_done &&
                   (cell_pt[IW'(r_idx)].x == cell_pt[IW'(r_idx - CW'(1))].x) &&
                   (cell_pt[IW'(r_idx)].y == cell_pt[IW'(r_idx - CW'(1))].y);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          if (opcode == OP_INSERT) state_next = S_SQUARE;
          else if (opcode == OP_DEDUP) state_next = S_DEDUP;
          else state_next = S_EXEC;
        end
      end
      S_SQUARE: state_next = S_EXEC;
      S_EXEC:   if (slot_free) state_next = S_IDLE;
      S_DEDUP:  if (dedup_done && slot_free) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  // row command and result
  always_comb begin
    cmd.kind   = CMD_HOLD;
    cmd.idx    = '0;
    cmd.count  = count;
    cmd.pt.key = sq_x + sq_y;
    cmd.pt.x   = px;
    cmd.pt.y   = py;
    count_next = count;
    finish     = 1'b0;
    res_status = ST_OK;
    case (state)
      S_EXEC: begin
        finish = slot_free;
        if (op_r == OP_INSERT) begin
          if (count >= CW'(DEPTH)) begin
            res_status = ST_FULL;
          end else if (slot_free) begin
            cmd.kind   = CMD_INS;
            count_next = count + CW'(1);
          end
        end else if (op_r == OP_FIRST || op_r == OP_LAST || op_r == OP_AT) begin
          if (!rem_ok) begin
            res_status = ST_NOT_FOUND;
          end else if (slot_free) begin
            cmd.kind   = CMD_DEL;
            cmd.idx    = rem_idx;
            count_next = count - CW'(1);
          end
        end
      end
      S_DEDUP: begin
        if (dup_hit) begin
          cmd.kind   = CMD_DEL;
          cmd.idx    = IW'(r_idx);
          count_next = count - CW'(1);
        end else if (dedup_done) begin
          finish = slot_free;
        end
      end
      default: cmd.kind = CMD_HOLD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      if (finish) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r  <= opcode;
      px    <= coord_x;
      py    <= coord_y;
      pos_r <= position;
      r_idx <= CW'(1);
      dups  <= '0;
    end
    if (state == S_SQUARE) begin
      sq_x <= ex * ex;
      sq_y <= ey * ey;
    end
    if (state == S_DEDUP && !dedup_done) begin
      if (dup_hit) begin
        if (dups != '1) dups <= dups + DUP_W'(1);
      end else begin
        r_idx <= r_idx + CW'(1);
      end
    end
    if (finish) begin
      status    <= res_status;
      out_x     <= '0;
      out_y     <= '0;
      dup_count <= '0;
      if (state == S_DEDUP) begin
        dup_count <= dups;
      end else if (op_r != OP_INSERT && rem_ok) begin
        out_x <= cell_pt[rem_idx].x;
        out_y <= cell_pt[rem_idx].y;
      end
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("fill count beyond depth");

  a_full_status: assert property (@(posedge clk) disable iff (rst)
    (finish && res_status == ST_FULL) |-> (count == CW'(DEPTH)))
    else $error("full status with free slot");

  a_remove_count: assert property (@(posedge clk) disable iff (rst)
    (state == S_EXEC && finish && op_r != OP_INSERT && rem_ok)
      |=> (count == $past(count) - CW'(1)))
    else $error("removal did not shrink queue");

endmodule

>>> dv/tb_top.sv
// self-checking testbench for the sorted point queue
module tb_top;
  import spq_pkg::*;

  typedef struct {
    logic [2:0]         op;
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic [3:0]         pos;
  } cmd_word_t;

  typedef struct {
    logic [1:0]         st;
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic [3:0]         dups;
  } reply_word_t;

  logic clk, rst;
  logic in_valid, in_stall;
  logic [2:0] opcode;
  logic signed [15:0] coord_x, coord_y;
  logic [3:0] position;
  logic out_valid, out_stall;
  logic [1:0] status;
  logic signed [15:0] out_x, out_y;
  logic [3:0] dup_count;

  sorted_point_queue u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .opcode(opcode), .coord_x(coord_x), .coord_y(coord_y), .position(position),
    .out_valid(out_valid), .out_stall(out_stall),
    .status(status), .out_x(out_x), .out_y(out_y), .dup_count(dup_count)
  );

  cmd_word_t   pending_cmds[$];
  reply_word_t expected_replies[$];
  int errors = 0;
  int replies_seen = 0;
  int dedup_hits = 0;
  bit drain_req = 0;

  // shadow copy of the ordered store
  logic signed [15:0] row_x[DEPTH];
  logic signed [15:0] row_y[DEPTH];
  logic [KEY_W-1:0]   row_key[DEPTH];
  int row_fill = 0;

  function automatic logic [KEY_W-1:0] dist_sq(logic signed [15:0] x, logic signed [15:0] y);
    logic signed [31:0] xx, yy;
    xx = x * x;
    yy = y * y;
    return KEY_W'(xx) + KEY_W'(yy);
  endfunction

  function automatic bit point_before(logic [KEY_W-1:0] ka, logic signed [15:0] xa,
                                      logic signed [15:0] ya, int j);
    if (ka != row_key[j]) return ka < row_key[j];
    if (xa != row_x[j]) return xa < row_x[j];
    return ya < row_y[j];
  endfunction

  function automatic reply_word_t apply_cmd(cmd_word_t c);
    reply_word_t r;
    int p, idx, w, removed;
    logic [KEY_W-1:0] k;
    r = '{ST_OK, 0, 0, 0};
    case (c.op)
      OP_INSERT: begin
        if (row_fill >= DEPTH) begin
          r.st = ST_FULL;
        end else begin
          k = dist_sq(c.x, c.y);
          p = row_fill;
          for (int i = 0; i < row_fill; i++)
            if (point_before(k, c.x, c.y, i)) begin
              p = i;
              break;
            end
          for (int i = row_fill; i > p; i--) begin
            row_x[i] = row_x[i-1]; row_y[i] = row_y[i-1]; row_key[i] = row_key[i-1];
          end
          row_x[p] = c.x; row_y[p] = c.y; row_key[p] = k;
          row_fill++;
        end
      end
      OP_FIRST, OP_LAST, OP_AT: begin
        idx = (c.op == OP_FIRST) ? 0 : (c.op == OP_LAST) ? row_fill - 1 : int'(c.pos);
        if (row_fill == 0 || idx >= row_fill) begin
          r.st = ST_NOT_FOUND;
        end else begin
          r.x = row_x[idx];
          r.y = row_y[idx];
          for (int i = idx; i + 1 < row_fill; i++) begin
            row_x[i] = row_x[i+1]; row_y[i] = row_y[i+1]; row_key[i] = row_key[i+1];
          end
          row_fill--;
        end
      end
      OP_DEDUP: begin
        removed = 0;
        if (row_fill >= 2) begin
          w = 1;
          for (int i = 1; i < row_fill; i++) begin
            if (row_x[i] == row_x[w-1] && row_y[i] == row_y[w-1]) begin
              removed++;
            end else begin
              row_x[w] = row_x[i]; row_y[w] = row_y[i]; row_key[w] = row_key[i];
              w++;
            end
          end
          row_fill = w;
        end
        r.dups = (removed > 15) ? 4'd15 : 4'(removed);
        if (removed > 0) dedup_hits++;
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    errors++;
    $display("mismatch on reply %0d: %s got %0d want %0d", replies_seen, what, got, want);
  endtask

  task automatic add_cmd(logic [2:0] op, logic signed [15:0] x, logic signed [15:0] y,
                         logic [3:0] pos);
    cmd_word_t c;
    c.op = op; c.x = x; c.y = y; c.pos = pos;
    pending_cmds.push_back(c);
  endtask

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  // driver: bursts and gaps, plus a drain request that holds off until all replies land
  int gap_left = 0;
  int burst_left = 0;
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 0;
      gap_left = 0;
      burst_left = 0;
    end else if (!in_valid || !in_stall) begin
      if (in_valid) expected_replies.push_back(apply_cmd('{opcode, coord_x, coord_y, position}));
      if (drain_req && (in_valid || expected_replies.size() != 0)) begin
        in_valid <= 0;
      end else if (drain_req) begin
        drain_req = 0;
        in_valid <= 0;
      end else if (gap_left > 0) begin
        gap_left--;
        in_valid <= 0;
      end else if (pending_cmds.size() != 0) begin
        cmd_word_t c;
        c = pending_cmds.pop_front();
        in_valid <= 1;
        opcode <= c.op; coord_x <= c.x; coord_y <= c.y; position <= c.pos;
        if (burst_left > 0) burst_left--;
        else begin
          burst_left = $urandom_range(0, 20);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 5);
        end
      end else begin
        in_valid <= 0;
      end
    end
  end

  // monitor and receiver stall pattern
  int stall_phase = 0;
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        reply_word_t e;
        replies_seen++;
        if (expected_replies.size() == 0) begin
          report_mismatch("unexpected reply", 1, 0);
        end else begin
          e = expected_replies.pop_front();
          if (status != e.st) report_mismatch("status", status, e.st);
          if (out_x != e.x) report_mismatch("out_x", out_x, e.x);
          if (out_y != e.y) report_mismatch("out_y", out_y, e.y);
          if (dup_count != e.dups) report_mismatch("dup_count", dup_count, e.dups);
        end
      end
      stall_phase++;
      if ((stall_phase / 300) % 3 == 2) out_stall <= 0;
      else out_stall <= ($urandom_range(0, 99) < ((stall_phase / 300) % 3 == 0 ? 30 : 70));
    end
  end

  function automatic logic signed [15:0] pick_coord();
    case ($urandom_range(0, 5))
      0: return 16'sh7fff;
      1: return 16'sh8000;
      2: return 16'(signed'($urandom_range(0, 6)) - 3);
      default: return 16'($urandom);
    endcase
  endfunction

  initial begin
    logic signed [15:0] x, y;
    rst = 1;
    in_valid = 0; out_stall = 0;
    opcode = 0; coord_x = 0; coord_y = 0; position = 0;

    // directed: empty removals, extremes, ties, full store, dedup, unused opcodes
    add_cmd(OP_FIRST, 0, 0, 0);
    add_cmd(OP_LAST, 0, 0, 0);
    add_cmd(OP_AT, 0, 0, 0);
    add_cmd(OP_DEDUP, 0, 0, 0);
    add_cmd(OP_INSERT, 16'sh7fff, 16'sh8000, 0);
    add_cmd(OP_INSERT, 16'sh8000, 16'sh8000, 0);
    add_cmd(OP_INSERT, 16'sh8000, 16'sh7fff, 0);
    add_cmd(OP_INSERT, 3, -4, 0);
    add_cmd(OP_INSERT, -4, 3, 0);
    add_cmd(OP_INSERT, 5, 0, 0);
    add_cmd(OP_INSERT, 3, -4, 0);
    add_cmd(OP_AT, 0, 0, 4'd15);
    add_cmd(OP_AT, 0, 0, 4'd2);
    add_cmd(OP_DEDUP, 0, 0, 0);
    add_cmd(3'd5, 1, 1, 1);
    add_cmd(3'd6, 0, 0, 0);
    add_cmd(3'd7, 0, 0, 0);
    for (int i = 0; i < 12; i++) add_cmd(OP_INSERT, 16'sh1234, -16'sh0055, 0);
    add_cmd(OP_INSERT, 0, 0, 0);
    add_cmd(OP_DEDUP, 0, 0, 0);

    // random: bias toward inserts of a small point set so duplicates and full appear
    for (int n = 0; n < 1900; n++) begin
      int r;
      r = $urandom_range(0, 99);
      if (r < 45) begin
        if ($urandom_range(0, 1)) begin
          x = 16'(signed'($urandom_range(0, 4)) - 2);
          y = 16'(signed'($urandom_range(0, 4)) - 2);
        end else begin
          x = pick_coord(); y = pick_coord();
        end
        add_cmd(OP_INSERT, x, y, 0);
      end else if (r < 57) add_cmd(OP_FIRST, 16'($urandom), 16'($urandom), 4'($urandom));
      else if (r < 69) add_cmd(OP_LAST, 0, 0, 4'($urandom));
      else if (r < 86) add_cmd(OP_AT, 0, 0, 4'($urandom));
      else if (r < 96) add_cmd(OP_DEDUP, 0, 0, 0);
      else add_cmd(3'($urandom_range(5, 7)), 16'($urandom), 16'($urandom), 4'($urandom));
    end

    repeat (10) @(posedge clk);
    rst <= 0;

    // hold the sender once mid-run until everything expected has drained
    wait (pending_cmds.size() < 1000);
    drain_req = 1;
    wait (pending_cmds.size() == 0 && !in_valid && expected_replies.size() == 0);
    repeat (60) @(posedge clk);
    $display("covered %0d replies over random insert, remove and dedup traffic", replies_seen);
    $display("dedup operations that removed points: %0d", dedup_hits);
    if (errors == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("timeout with %0d replies still expected", expected_replies.size());
    $display("tb_top: FAIL");
    $finish;
  end
endmodule
